// File: sv/rsfs_pkg.sv
// Shared types, codes and constants for the RGB scene fade sequencer.
// No dependencies; every other file refers to this package by scoped names.
package rsfs_pkg;

  localparam int SCENE_SLOTS = 8;
  localparam int IDX_W       = 3;
  localparam int DIV_STEPS   = 13;
  localparam int PERIOD_BASE = 1000;
  localparam int PERIOD_MUL  = 20;
  localparam logic [12:0] PERIOD_SAT = 13'd6100;

  localparam logic [1:0] OP_BASE   = 2'd0;
  localparam logic [1:0] OP_SCENE  = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] MODE_BREATHE = 2'd0;
  localparam logic [1:0] MODE_DECAY   = 2'd1;
  localparam logic [1:0] MODE_JUMP    = 2'd2;
  localparam logic [1:0] MODE_FADE    = 2'd3;

  localparam logic [1:0] CH_NONE = 2'd3;

  localparam logic [1:0] DIR_UNCHANGED = 2'd0;
  localparam logic [1:0] DIR_UP        = 2'd1;
  localparam logic [1:0] DIR_DOWN      = 2'd2;

  localparam logic [1:0] CFG_FREQ  = 2'd0;
  localparam logic [1:0] CFG_COUNT = 2'd1;

  // Slot of the shared divider that computes the period.
  localparam logic [1:0] SLOT_PERIOD = 2'd3;

  // Colour triple, element 0 is red, 1 green, 2 blue.
  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] mode;
    logic [1:0] channel;
    logic [2:0] entry_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_beat_t;

  typedef struct packed {
    logic        segment_done;
    logic [12:0] step_period;
    logic [7:0]  ratio_red;
    logic [7:0]  ratio_green;
    logic [7:0]  ratio_blue;
    logic [7:0]  level_red;
    logic [7:0]  level_green;
    logic [7:0]  level_blue;
    logic [2:0]  scene_index_out;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_JUMP_LD,
    S_FADE_LD,
    S_DIV_LOAD,
    S_DIV_RUN,
    S_DIV_STORE,
    S_OUT
  } state_e;

  typedef struct packed {
    logic       capture;
    logic       exec;
    logic       jump_ld;
    logic       fade_ld;
    logic       div_start;
    logic       div_store;
    logic       out_load;
    logic [1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic seg_jump;
    logic seg_fade;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

// File: sv/rsfs_ctrl.sv
// Sequencer state machine: item capture, update, segment timing, result beat.
// Depends on rsfs_pkg; drives the datapath through cmd_t, reads status_t.
module rsfs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  rsfs_pkg::status_t status_i,
  output rsfs_pkg::cmd_t    cmd_o,
  output logic              busy_o
);

  rsfs_pkg::state_e state_q, state_d;
  logic [1:0] slot_q, slot_d;

  // State and slot registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsfs_pkg::S_IDLE;
      slot_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    case (state_q)
      rsfs_pkg::S_IDLE: begin
        if (in_valid_i) state_d = rsfs_pkg::S_EXEC;
      end
      rsfs_pkg::S_EXEC: begin
        if (status_i.seg_jump)      state_d = rsfs_pkg::S_JUMP_LD;
        else if (status_i.seg_fade) state_d = rsfs_pkg::S_FADE_LD;
        else                        state_d = rsfs_pkg::S_OUT;
      end
      rsfs_pkg::S_JUMP_LD, rsfs_pkg::S_FADE_LD: begin
        slot_d  = 2'd0;
        state_d = rsfs_pkg::S_DIV_LOAD;
      end
      rsfs_pkg::S_DIV_LOAD: state_d = rsfs_pkg::S_DIV_RUN;
      rsfs_pkg::S_DIV_RUN: begin
        if (!status_i.div_busy) state_d = rsfs_pkg::S_DIV_STORE;
      end
      rsfs_pkg::S_DIV_STORE: begin
        if (slot_q == rsfs_pkg::SLOT_PERIOD) begin
          state_d = rsfs_pkg::S_OUT;
        end else begin
          slot_d  = slot_q + 2'd1;
          state_d = rsfs_pkg::S_DIV_LOAD;
        end
      end
      rsfs_pkg::S_OUT: begin
        if (status_i.out_free) state_d = rsfs_pkg::S_IDLE;
      end
      default: state_d = rsfs_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.slot = slot_q;
    busy_o     = (state_q != rsfs_pkg::S_IDLE);
    case (state_q)
      rsfs_pkg::S_IDLE:      cmd_o.capture   = in_valid_i;
      rsfs_pkg::S_EXEC:      cmd_o.exec      = 1'b1;
      rsfs_pkg::S_JUMP_LD:   cmd_o.jump_ld   = 1'b1;
      rsfs_pkg::S_FADE_LD:   cmd_o.fade_ld   = 1'b1;
      rsfs_pkg::S_DIV_LOAD:  cmd_o.div_start = 1'b1;
      rsfs_pkg::S_DIV_RUN:   cmd_o.div_start = 1'b0;
      rsfs_pkg::S_DIV_STORE: cmd_o.div_store = 1'b1;
      rsfs_pkg::S_OUT:       cmd_o.out_load  = status_i.out_free;
      default:               cmd_o           = '0;
    endcase
  end

endmodule

// File: sv/rsfs_datapath.sv
// Sequencer datapath: colour state, scene table memory, shared divider,
// configuration registers and the result register. Depends on rsfs_pkg.
module rsfs_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rsfs_pkg::in_beat_t  in_i,
  input  rsfs_pkg::cmd_t      cmd_i,
  output rsfs_pkg::status_t   status_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output rsfs_pkg::out_beat_t out_o
);

  rsfs_pkg::in_beat_t item_q;
  rsfs_pkg::rgb_t base_q, lvl_q, vec_q, ratio_q, rd_q;
  logic [2:0][1:0] dir_q;
  logic rising_q;
  logic [rsfs_pkg::IDX_W-1:0] idx_q;
  logic [1:0] top_q;
  logic done_q;
  logic [12:0] period_q;
  logic [7:0] freq_q;
  logic [3:0] count_q;
  logic [7:0] rem_q, den_q;
  logic [12:0] quo_q;
  logic [3:0] cnt_q;
  logic out_valid_q;
  rsfs_pkg::out_beat_t out_q;
  rsfs_pkg::rgb_t mem_q [rsfs_pkg::SCENE_SLOTS];

  // Item decode
  logic [1:0] ch;
  logic tick, fade_up, reached, exec_done;
  logic [7:0] cur_lv, base_ch, tgt_ch;
  rsfs_pkg::rgb_t rgb_in;
  assign ch     = item_q.channel;
  assign tick   = (item_q.op == rsfs_pkg::OP_TICK) && (ch != rsfs_pkg::CH_NONE);
  assign rgb_in = {item_q.blue_in, item_q.green_in, item_q.red_in};

  always_comb begin
    cur_lv  = 8'd0;
    base_ch = 8'd0;
    tgt_ch  = 8'd0;
    fade_up = 1'b0;
    if (ch != rsfs_pkg::CH_NONE) begin
      cur_lv  = lvl_q[ch];
      base_ch = base_q[ch];
      tgt_ch  = rd_q[ch];
      fade_up = (dir_q[ch] == rsfs_pkg::DIR_UP);
    end
  end

  assign reached = fade_up ? (cur_lv >= tgt_ch) : (cur_lv <= tgt_ch);

  always_comb begin
    exec_done = 1'b0;
    if (tick) begin
      case (item_q.mode)
        rsfs_pkg::MODE_BREATHE: exec_done = rising_q ? (cur_lv >= base_ch) : (cur_lv == 8'd0);
        rsfs_pkg::MODE_DECAY:   exec_done = (cur_lv == 8'd0);
        rsfs_pkg::MODE_JUMP:    exec_done = (cur_lv == 8'd0);
        rsfs_pkg::MODE_FADE:    exec_done = reached;
        default:                exec_done = 1'b0;
      endcase
    end
  end

  assign status_o.seg_jump = tick && (item_q.mode == rsfs_pkg::MODE_JUMP) && exec_done;
  assign status_o.seg_fade = tick && (item_q.mode == rsfs_pkg::MODE_FADE) && exec_done;

  // Scene index advance, wrapping at the smaller of count and table size
  logic [4:0] limit, inc;
  logic [rsfs_pkg::IDX_W-1:0] next_idx;
  always_comb begin
    limit    = (5'(count_q) < 5'(rsfs_pkg::SCENE_SLOTS)) ? 5'(count_q)
                                                          : 5'(rsfs_pkg::SCENE_SLOTS);
    inc      = 5'(idx_q) + 5'd1;
    next_idx = (inc >= limit) ? '0 : inc[rsfs_pkg::IDX_W-1:0];
  end

  // Fade targets: direction and distance from the old entry to the new one
  rsfs_pkg::rgb_t delta;
  logic [2:0][1:0] dir_new;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (base_q[c] > rd_q[c]) begin
        dir_new[c] = rsfs_pkg::DIR_DOWN;
        delta[c]   = base_q[c] - rd_q[c];
      end else if (base_q[c] == rd_q[c]) begin
        dir_new[c] = rsfs_pkg::DIR_UNCHANGED;
        delta[c]   = 8'd0;
      end else begin
        dir_new[c] = rsfs_pkg::DIR_UP;
        delta[c]   = rd_q[c] - base_q[c];
      end
    end
  end

  // Largest channel: jump ties go to the later channel, fade ties to the earlier
  logic [1:0] top_jump, top_fade;
  always_comb begin
    if (rd_q[0] > rd_q[1]) top_jump = (rd_q[0] > rd_q[2]) ? 2'd0 : 2'd2;
    else                   top_jump = (rd_q[1] > rd_q[2]) ? 2'd1 : 2'd2;
    if (delta[0] >= delta[1]) top_fade = (delta[0] >= delta[2]) ? 2'd0 : 2'd2;
    else                      top_fade = (delta[1] >= delta[2]) ? 2'd1 : 2'd2;
  end

  // Scene table write port and registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && (item_q.op == rsfs_pkg::OP_SCENE) &&
        (32'(item_q.entry_index) < rsfs_pkg::SCENE_SLOTS)) begin
      mem_q[item_q.entry_index] <= rgb_in;
    end
    rd_q <= mem_q[cmd_i.exec ? next_idx : idx_q];
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q  <= 8'd0;
      count_q <= 4'd1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == rsfs_pkg::CFG_FREQ)  freq_q  <= cfg_data_i;
      if (cfg_index_i == rsfs_pkg::CFG_COUNT) count_q <= cfg_data_i[3:0];
    end
  end

  // Captured item
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_i;
  end

  // Colour and sequencing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      lvl_q    <= '0;
      rising_q <= 1'b1;
      idx_q    <= '0;
      dir_q    <= '0;
      vec_q    <= '0;
      top_q    <= 2'd0;
      done_q   <= 1'b0;
    end else begin
      if (cmd_i.capture) done_q <= 1'b0;
      if (cmd_i.exec) begin
        done_q <= exec_done;
        if (item_q.op == rsfs_pkg::OP_BASE) base_q <= rgb_in;
        if (tick) begin
          case (item_q.mode)
            rsfs_pkg::MODE_BREATHE: begin
              if (rising_q) begin
                if (exec_done) begin
                  rising_q <= 1'b0;
                  lvl_q    <= base_q;
                end else lvl_q[ch] <= cur_lv + 8'd1;
              end else begin
                if (exec_done) begin
                  rising_q <= 1'b1;
                  lvl_q    <= '0;
                end else lvl_q[ch] <= cur_lv - 8'd1;
              end
            end
            rsfs_pkg::MODE_DECAY: begin
              if (exec_done) lvl_q <= base_q;
              else           lvl_q[ch] <= cur_lv - 8'd1;
            end
            rsfs_pkg::MODE_JUMP: begin
              if (exec_done) idx_q <= next_idx;
              else           lvl_q[ch] <= cur_lv - 8'd1;
            end
            rsfs_pkg::MODE_FADE: begin
              if (exec_done) begin
                base_q <= rd_q;
                lvl_q  <= rd_q;
                idx_q  <= next_idx;
              end else if (fade_up) lvl_q[ch] <= cur_lv + 8'd1;
              else                  lvl_q[ch] <= cur_lv - 8'd1;
            end
            default: lvl_q <= lvl_q;
          endcase
        end
      end
      // New scene entry has arrived from the table
      if (cmd_i.jump_ld) begin
        base_q <= rd_q;
        lvl_q  <= rd_q;
        vec_q  <= rd_q;
        top_q  <= top_jump;
      end
      if (cmd_i.fade_ld) begin
        dir_q <= dir_new;
        vec_q <= delta;
        top_q <= top_fade;
      end
    end
  end

  // Shared restoring divider, one quotient bit per cycle
  logic [8:0] trial;
  logic ge;
  logic [12:0] num_sel;
  logic [7:0] den_sel;
  assign trial = {rem_q, quo_q[12]};
  assign ge    = (trial >= {1'b0, den_q});
  always_comb begin
    if (cmd_i.slot == rsfs_pkg::SLOT_PERIOD) begin
      num_sel = 13'(rsfs_pkg::PERIOD_BASE) + 13'(freq_q) * 13'(rsfs_pkg::PERIOD_MUL);
      den_sel = vec_q[top_q];
    end else begin
      num_sel = 13'(vec_q[top_q]);
      den_sel = vec_q[cmd_i.slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 4'd0;
    end else if (cmd_i.div_start) begin
      cnt_q <= 4'(rsfs_pkg::DIV_STEPS);
    end else if (cnt_q != 4'd0) begin
      cnt_q <= cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= 8'd0;
      quo_q <= num_sel;
      den_q <= den_sel;
    end else if (cnt_q != 4'd0) begin
      rem_q <= ge ? 8'(trial - {1'b0, den_q}) : trial[7:0];
      quo_q <= {quo_q[11:0], ge};
    end
  end

  assign status_o.div_busy = (cnt_q != 4'd0);

  // Quotient store, with the largest channel and zero divisors fixed up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q  <= '0;
      period_q <= 13'd0;
    end else begin
      if (cmd_i.capture) period_q <= 13'd0;
      if (cmd_i.div_store) begin
        if (cmd_i.slot == rsfs_pkg::SLOT_PERIOD) begin
          period_q <= (den_q == 8'd0) ? rsfs_pkg::PERIOD_SAT : quo_q;
        end else if (cmd_i.slot == top_q) begin
          ratio_q[cmd_i.slot] <= 8'd1;
        end else begin
          ratio_q[cmd_i.slot] <= (den_q == 8'd0) ? 8'd0 : quo_q[7:0];
        end
      end
    end
  end

  // Result register
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= {done_q, period_q, ratio_q[0], ratio_q[1], ratio_q[2],
                lvl_q[0], lvl_q[1], lvl_q[2], idx_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: sv/rgb_scene_fade_sequencer_core.sv
// RGB scene fade sequencer, top level: controller plus datapath.
// Sequence: a beat is captured, executed and loaded into the output register; a jump or
// fade segment end adds a scene load and four divider passes: three ratios and the period.
// No new beat is taken while one is in work, and output stalls hold the block busy; the next
// beat is taken once the result is in the output register. Reset sets control, colour and
// configuration registers to defaults; scene table contents are undefined until written.
module rgb_scene_fade_sequencer_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rsfs_pkg::in_beat_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rsfs_pkg::out_beat_t out_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);

  rsfs_pkg::cmd_t    cmd;
  rsfs_pkg::status_t status;
  logic busy;

  assign in_stall_o  = busy;
  assign cfg_ready_o = 1'b1;

  rsfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  rsfs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

// File: sv/rsfs_checker.sv
// Port-level checks for the sequencer top level, bound into it below.
// Depends on rsfs_pkg and rgb_scene_fade_sequencer_core.
module rsfs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rsfs_pkg::out_beat_t out_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

  // An accepted beat makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("beat accepted while not going busy");

  // A period is reported only with a segment end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.segment_done |-> out_o.step_period == 13'd0)
    else $error("period without segment end");

  // A new result follows work on a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a beat in work");

endmodule

bind rgb_scene_fade_sequencer_core rsfs_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);
